// ===== rtl/core/ppcm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppcm_pkg
// Shared constants and controller/datapath interface types of the PWM pulse
// capture meter.
// ----------------------------------------------------------------------------
package ppcm_pkg;

  // Default width of the capture timer
  localparam int unsigned TimerBitsDef = 16;

  // Duty scale and width of the duty quotient (0..100 fits in 7 bits)
  localparam int unsigned PctScale = 100;
  localparam int unsigned QuotBits = 7;

  // Controller states
  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StDiv,
    StDone
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // take the capture, update periods and phase
    logic mul;   // form on*100 and preload the divider
    logic step;  // one restoring division step
    logic emit;  // load the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_last;  // current step is the last quotient bit
    logic out_free;  // output register can take a new result
  } dp_status_t;

endpackage

// ===== rtl/core/ppcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppcm_ctrl
// Sequencer of the meter: accepts one capture, runs the multiply and the
// division steps, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ppcm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ppcm_pkg::dp_status_t   status_i,
  output ppcm_pkg::ctrl_cmd_t    cmd_o
);

  ppcm_pkg::state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppcm_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance through accept, multiply, divide and output
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ppcm_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ppcm_pkg::StMul;
        end
      end
      ppcm_pkg::StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = ppcm_pkg::StDiv;
      end
      ppcm_pkg::StDiv: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) begin
          state_d = ppcm_pkg::StDone;
        end
      end
      ppcm_pkg::StDone: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ppcm_pkg::StIdle;
        end
      end
      default: begin
        state_d = ppcm_pkg::StIdle;
      end
    endcase
  end

endmodule

// ===== rtl/core/ppcm_dp.sv =====
// ----------------------------------------------------------------------------
// ppcm_dp
// Datapath of the meter: period registers, on*100 multiplier, seven-step
// restoring divider for the duty percent and the output register.
// ----------------------------------------------------------------------------
module ppcm_dp #(
  parameter int unsigned TimerBits = ppcm_pkg::TimerBitsDef,
  parameter int unsigned OutWidth  = ((3 * TimerBits + 10 + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [TimerBits-1:0]   capture_time_i,
  input  ppcm_pkg::ctrl_cmd_t    cmd_i,
  output ppcm_pkg::dp_status_t   status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OutWidth-1:0]    out_data_o
);

  localparam int unsigned QB  = ppcm_pkg::QuotBits;
  localparam int unsigned NumW = TimerBits + QB;  // width of on*100 and shifted divisor
  localparam int unsigned CntW = $clog2(QB);

  // Measurement state
  logic                 expect_falling_q;
  logic [TimerBits-1:0] prev_time_q;
  logic [TimerBits-1:0] on_q;
  logic [TimerBits-1:0] off_q;
  logic [TimerBits:0]   total_q;

  // Divider
  logic [NumW-1:0]      rem_q;
  logic [NumW-1:0]      dsr_q;
  logic [QB-1:0]        quot_q;
  logic [CntW-1:0]      cnt_q;

  // Output register
  logic                 out_valid_q;
  logic [TimerBits-1:0] hi_out_q;
  logic [TimerBits-1:0] lo_out_q;
  logic [TimerBits:0]   tot_out_q;
  logic [QB-1:0]        duty_out_q;
  logic                 dvalid_out_q;
  logic                 arm_out_q;

  logic [TimerBits-1:0] delta;
  logic [TimerBits-1:0] on_d;
  logic [TimerBits-1:0] off_d;
  logic                 ge;
  logic                 total_nz;

  // Form the modular difference and pick the period it belongs to
  assign delta = capture_time_i - prev_time_q;
  assign on_d  = expect_falling_q ? delta : on_q;
  assign off_d = expect_falling_q ? off_q : delta;

  // Update phase, last capture, periods and their full-width sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_falling_q <= 1'b0;
      prev_time_q      <= '0;
      on_q             <= '0;
      off_q            <= '0;
      total_q          <= '0;
    end else if (cmd_i.load) begin
      expect_falling_q <= ~expect_falling_q;
      prev_time_q      <= capture_time_i;
      on_q             <= on_d;
      off_q            <= off_d;
      total_q          <= {1'b0, on_d} + {1'b0, off_d};
    end
  end

  // Restoring division: quotient is below 2^QB, so QB steps of a shifted divisor
  assign ge = (rem_q >= dsr_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rem_q  <= NumW'(on_q) * NumW'(ppcm_pkg::PctScale);
      dsr_q  <= NumW'(total_q) << (QB - 1);
      quot_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.step) begin
      rem_q  <= ge ? (rem_q - dsr_q) : rem_q;
      dsr_q  <= dsr_q >> 1;
      quot_q <= {quot_q[QB-2:0], ge};
      cnt_q  <= cnt_q + CntW'(1);
    end
  end

  assign total_nz          = (total_q != '0);
  assign status_o.div_last = (cnt_q == CntW'(QB - 1));
  assign status_o.out_free = ~out_valid_q | out_ready_i;

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result fields; zero total forces duty to 0
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      hi_out_q     <= on_q;
      lo_out_q     <= off_q;
      tot_out_q    <= total_q;
      duty_out_q   <= total_nz ? quot_q : '0;
      dvalid_out_q <= total_nz;
      arm_out_q    <= ~expect_falling_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = OutWidth'({arm_out_q, dvalid_out_q, duty_out_q,
                                  tot_out_q, lo_out_q, hi_out_q});

  // Checks
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (duty_out_q <= QB'(ppcm_pkg::PctScale)))
    else $error("duty percent above 100");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (~out_valid_q | out_ready_i))
    else $error("result loaded over an untaken result");

  a_total_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q == ({1'b0, on_q} + {1'b0, off_q}))
    else $error("total period out of step with the periods");

  a_valid_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (dvalid_out_q == (tot_out_q != '0)))
    else $error("duty valid flag disagrees with total period");

endmodule

// ===== rtl/core/pwm_pulse_capture_meter.sv =====
// ----------------------------------------------------------------------------
// pwm_pulse_capture_meter
// Measures on and off periods and the duty percent of a PWM signal from
// alternating edge capture timestamps.
// ----------------------------------------------------------------------------
// Each slave transaction carries one capture timestamp; edges alternate and
// the first edge after reset is rising. A rising edge sets the off period,
// a falling edge the on period, both as the difference modulo 2^TimerBits
// from the previous capture. Every capture yields one master transaction
// with both periods, their full-width sum, the truncated duty percent
// (0 with duty_valid low when the total is zero) and the edge to arm next.
// An item passes from acceptance to result through the period update, the
// on*100 multiply, the seven steps of the restoring divider that form the
// duty quotient and the load of the output register. A new capture is
// accepted only once the previous one has reached the output register;
// the output register lets a capture be accepted while the previous
// result still waits.
module pwm_pulse_capture_meter #(
  parameter int unsigned TimerBits = ppcm_pkg::TimerBitsDef,
  parameter int unsigned InWidth   = ((TimerBits + 7) / 8) * 8,
  parameter int unsigned OutWidth  = ((3 * TimerBits + 10 + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // capture_time [TimerBits-1:0]
  input  logic [InWidth-1:0]  s_axis_tdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // high_period, low_period, total_period (TimerBits+1), duty_percent (7),
  // duty_valid, arm_rising_edge, from the lowest bit up
  output logic [OutWidth-1:0] m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready
);

  ppcm_pkg::ctrl_cmd_t  cmd;
  ppcm_pkg::dp_status_t status;

  // Sequence one capture at a time
  ppcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Periods, duty divider and output register
  ppcm_dp #(
    .TimerBits (TimerBits),
    .OutWidth  (OutWidth)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .capture_time_i (s_axis_tdata[TimerBits-1:0]),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata)
  );

endmodule

// ===== tb/pwm_pulse_capture_meter_test.sv =====
// ----------------------------------------------------------------------------
// pwm_pulse_capture_meter_test
// Self-checking bench for the PWM pulse capture meter: streams capture
// timestamps in, predicts every period and duty reading and compares each
// reading field by field as it leaves the block.
// ----------------------------------------------------------------------------
module pwm_pulse_capture_meter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TimerBits  = ppcm_pkg::TimerBitsDef;
  localparam int unsigned InWidth    = ((TimerBits + 7) / 8) * 8;
  localparam int unsigned OutWidth   = ((3 * TimerBits + 10 + 7) / 8) * 8;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainWait  = 30;
  localparam int unsigned ReportMax  = 10;

  // One reading as packed on the master tdata, highest field first
  typedef struct packed {
    logic [OutWidth-3*TimerBits-11:0] pad;
    logic                             arm_rising;
    logic                             duty_valid;
    logic [ppcm_pkg::QuotBits-1:0]    duty_percent;
    logic [TimerBits:0]               total_period;
    logic [TimerBits-1:0]             low_period;
    logic [TimerBits-1:0]             high_period;
  } meter_reading_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [InWidth-1:0]  s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutWidth-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;

  // Predictor state of the meter
  logic                 pred_falling_next;
  logic [TimerBits-1:0] pred_last_capture;
  logic [TimerBits-1:0] pred_on_ticks;
  logic [TimerBits-1:0] pred_off_ticks;

  meter_reading_t       pending_readings[$];
  logic [TimerBits-1:0] last_sent_capture;
  int unsigned          send_idle_pct;
  int unsigned          recv_idle_pct;
  int unsigned          mismatch_count;
  int unsigned          capture_count;
  int unsigned          reading_count;
  int unsigned          directed_count;
  int unsigned          stall_cycles;

  pwm_pulse_capture_meter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Advance the predictor by one edge and return the reading it yields
  function automatic meter_reading_t predict_reading(logic [TimerBits-1:0] capture);
    meter_reading_t       r;
    logic [TimerBits-1:0] delta;
    logic [TimerBits:0]   total;
    logic [31:0]          scaled;
    delta = capture - pred_last_capture;
    if (pred_falling_next) begin
      pred_on_ticks = delta;
    end else begin
      pred_off_ticks = delta;
    end
    pred_falling_next = !pred_falling_next;
    pred_last_capture = capture;
    total = {1'b0, pred_on_ticks} + {1'b0, pred_off_ticks};
    r = '0;
    r.high_period  = pred_on_ticks;
    r.low_period   = pred_off_ticks;
    r.total_period = total;
    if (total != 0) begin
      scaled         = 32'(pred_on_ticks) * ppcm_pkg::PctScale;
      r.duty_percent = ppcm_pkg::QuotBits'(scaled / 32'(total));
      r.duty_valid   = 1'b1;
    end
    r.arm_rising = !pred_falling_next;
    return r;
  endfunction

  // Send one capture, idling at random beforehand, and log its reading
  task automatic send_capture(input logic [TimerBits-1:0] capture);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InWidth'(capture);
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pending_readings.push_back(predict_reading(capture));
    last_sent_capture = capture;
    capture_count++;
  endtask

  // Send the next edge a given number of ticks after the previous one
  task automatic send_edge(input int unsigned ticks);
    send_capture(last_sent_capture + TimerBits'(ticks));
  endtask

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= ReportMax) begin
      $display("mismatch in reading %0d, %s: expected %0d, got %0d",
               reading_count, field, want, got);
    end
  endtask

  // Drive the receiver ready at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each reading against the oldest prediction
  always @(posedge clk_i) begin
    meter_reading_t want;
    meter_reading_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = meter_reading_t'(m_axis_tdata);
      if (pending_readings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportMax) begin
          $display("reading with no capture pending: tdata %h", m_axis_tdata);
        end
      end else begin
        want = pending_readings.pop_front();
        if (got.high_period !== want.high_period)
          report_mismatch("high_period", 32'(want.high_period), 32'(got.high_period));
        if (got.low_period !== want.low_period)
          report_mismatch("low_period", 32'(want.low_period), 32'(got.low_period));
        if (got.total_period !== want.total_period)
          report_mismatch("total_period", 32'(want.total_period),
                          32'(got.total_period));
        if (got.duty_percent !== want.duty_percent)
          report_mismatch("duty_percent", 32'(want.duty_percent),
                          32'(got.duty_percent));
        if (got.duty_valid !== want.duty_valid)
          report_mismatch("duty_valid", 32'(want.duty_valid), 32'(got.duty_valid));
        if (got.arm_rising !== want.arm_rising)
          report_mismatch("arm_rising_edge", 32'(want.arm_rising), 32'(got.arm_rising));
      end
      reading_count++;
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("timeout: no transaction for %0d cycles", StallLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // First edges from reset: both periods zero, duty flagged invalid
  task automatic test_first_edge_zero_total();
    send_capture('0);
    send_capture('0);
  endtask

  // Largest, smallest and mixed periods, including a zero total mid-run
  task automatic test_period_extremes();
    send_edge(16'hFFFF);
    send_edge(16'hFFFF);
    send_edge(0);
    send_edge(1);
    send_edge(1);
    send_edge(0);
    send_edge(0);
    send_edge(3);
    send_edge(16'hFFFF);
  endtask

  // Timer rollover between edges and the capture value extremes
  task automatic test_counter_wrap();
    send_capture(16'hFFF0);
    send_capture(16'h0010);
    send_capture(16'hFFFF);
    send_capture(16'h0000);
  endtask

  // Bursts of a steady PWM wave with jitter, in small, medium and full ranges
  task automatic test_random_waveforms(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    int unsigned on_nom;
    int unsigned off_nom;
    int unsigned jitter;
    int unsigned span;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(3))
        0: span = 20;
        1: span = 1000;
        default: span = 65535;
      endcase
      on_nom  = $urandom_range(span);
      off_nom = $urandom_range(span);
      if ($urandom_range(9) == 0) on_nom = 0;
      if ($urandom_range(9) == 0) off_nom = 0;
      jitter = $urandom_range(3);
      burst  = $urandom_range(60, 10);
      repeat (burst) begin
        if (sent < count) begin
          if (pred_falling_next) send_edge(on_nom + $urandom_range(jitter));
          else send_edge(off_nom + $urandom_range(jitter));
          sent++;
        end
      end
    end
  endtask

  // Unrelated captures as noise
  task automatic test_random_captures(input int unsigned count);
    repeat (count) send_capture(TimerBits'($urandom_range(16'hFFFF)));
  endtask

  initial begin
    pred_falling_next = 1'b0;
    pred_last_capture = '0;
    pred_on_ticks     = '0;
    pred_off_ticks    = '0;
    last_sent_capture = '0;
    send_idle_pct     = 33;
    recv_idle_pct     = 69;
    mismatch_count    = 0;
    capture_count     = 0;
    reading_count     = 0;
    stall_cycles      = 0;

    // Hold reset low, then release it
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_edge_zero_total();
    test_period_extremes();
    test_counter_wrap();
    directed_count = capture_count;

    // Sender lightly idle, receiver mostly stalled
    test_random_waveforms(330);
    test_random_captures(85);
    // Sender mostly idle, receiver lightly stalled
    send_idle_pct = 69;
    recv_idle_pct = 33;
    test_random_waveforms(330);
    test_random_captures(85);
    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_waveforms(330);
    test_random_captures(85);

    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d captures (%0d directed) and checked %0d readings,",
             capture_count, directed_count, reading_count);
    $display("covering zero totals, rollover, full-range periods and three stall mixes.");
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d readings missing", mismatch_count,
               pending_readings.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
